// File: rtl/core/sbm_pkg.sv
// Shared constants, types and helpers for the signature byte stream matcher.
package sbm_pkg;

	localparam int SIG_COUNT = 16;
	localparam int SIG_MAX   = 15;
	localparam int POS_W     = $clog2(SIG_MAX + 1);
	localparam int IDX_W     = $clog2(SIG_COUNT);
	localparam int LIMIT_W   = 25;

	localparam logic [LIMIT_W-1:0] LIMIT_RESET = LIMIT_W'(1024 * 1024);

	typedef logic [7:0]           byte_t;
	typedef logic [SIG_COUNT-1:0] sig_mask_t;
	typedef logic [IDX_W-1:0]     sig_idx_t;
	typedef logic [POS_W-1:0]     sig_pos_t;
	typedef logic [LIMIT_W-1:0]   limit_t;
	typedef logic [SIG_MAX*8-1:0] sig_text_t;

	// Text is right-justified: the last character sits in the low byte.
	localparam sig_text_t SIG_TEXT [SIG_COUNT] = '{
		sig_text_t'("rm -rf /"),
		sig_text_t'("rm -rf /*"),
		sig_text_t'("mkfs"),
		sig_text_t'("dd if=/dev/zero"),
		sig_text_t'("> /dev/sda"),
		sig_text_t'("drop table"),
		sig_text_t'("eval("),
		sig_text_t'("exec("),
		sig_text_t'("system("),
		sig_text_t'("popen("),
		sig_text_t'("; rm "),
		sig_text_t'("| sh"),
		sig_text_t'(8'h60),
		sig_text_t'("$("),
		sig_text_t'("wget.*| sh"),
		sig_text_t'("curl.*| sh")
	};

	localparam sig_pos_t SIG_LEN [SIG_COUNT] = '{
		POS_W'(8), POS_W'(9), POS_W'(4), POS_W'(15),
		POS_W'(10), POS_W'(10), POS_W'(5), POS_W'(5),
		POS_W'(7), POS_W'(6), POS_W'(5), POS_W'(4),
		POS_W'(1), POS_W'(2), POS_W'(10), POS_W'(10)
	};

	typedef struct packed {
		logic      verdict;
		sig_idx_t  first_signature;
		sig_mask_t found_mask;
	} result_t;

	// Lowest set bit index; zero for an empty mask.
	function automatic sig_idx_t first_set(input sig_mask_t m);
		sig_idx_t r;
		r = '0;
		for (int k = SIG_COUNT - 1; k >= 0; k--) begin
			if (m[k]) r = IDX_W'(k);
		end
		return r;
	endfunction

endpackage

// File: rtl/core/sbm_if.sv
// Channel interfaces: input word, result word and limit register write.
interface sbm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       byte_present;
	logic       end_of_file;
	modport source (output valid, data_byte, byte_present, end_of_file, input ready);
	modport sink   (input valid, data_byte, byte_present, end_of_file, output ready);
endinterface

interface sbm_out_if;
	logic        valid;
	logic        ready;
	logic        verdict;
	logic [3:0]  first_signature;
	logic [15:0] found_mask;
	modport source (output valid, verdict, first_signature, found_mask, input ready);
	modport sink   (input valid, verdict, first_signature, found_mask, output ready);
endinterface

interface sbm_cfg_if;
	logic        valid;
	logic        ready;
	logic [24:0] scan_byte_limit;
	modport source (output valid, scan_byte_limit, input ready);
	modport sink   (input valid, scan_byte_limit, output ready);
endinterface

// File: rtl/core/sbm_cell.sv
// One window cell: holds a byte, passes it on, compares its column of every signature.
module sbm_cell (
	input  logic              clk,
	input  logic              arst_n,
	input  sbm_pkg::sig_pos_t pos,
	input  logic              shift,
	input  logic              clear,
	input  sbm_pkg::byte_t    byte_in,
	output sbm_pkg::byte_t    byte_q,
	output sbm_pkg::sig_mask_t col_hit
);
	import sbm_pkg::*;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (clear) begin
			byte_q <= '0;
		end else if (shift) begin
			byte_q <= byte_in;
		end
	end

	// Positions past a signature's length do not constrain it.
	always_comb begin
		for (int k = 0; k < SIG_COUNT; k++) begin
			col_hit[k] = (pos >= SIG_LEN[k]) ||
				(byte_in == SIG_TEXT[k][8*pos +: 8]);
		end
	end
endmodule

// File: rtl/core/sbm_out_stage.sv
// Result register: holds one verdict word until the sink takes it.
module sbm_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  sbm_pkg::result_t res_in,
	output logic             free,
	sbm_out_if.source        result
);
	import sbm_pkg::*;

	logic    vld_q;
	result_t res_q;

	assign free = !vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (load) begin
			vld_q <= 1'b1;
		end else if (result.ready) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_in;
	end

	assign result.valid           = vld_q;
	assign result.verdict         = res_q.verdict;
	assign result.first_signature = res_q.first_signature;
	assign result.found_mask      = res_q.found_mask;
endmodule

// File: rtl/core/signature_byte_stream_matcher_core.sv
// Top level of the signature byte stream matcher.
//
// Usage:
//   item   : one word per file byte (data_byte, byte_present, end_of_file).
//            A word with byte_present low carries no byte; with end_of_file
//            high it closes the file (an empty file reads as clean).
//   result : one verdict word per file, sent for the word with end_of_file.
//            verdict, lowest signature index found and the full found mask.
//   cfg    : write of scan_byte_limit; always ready. Write only while idle.
// Throughput: one word per cycle while item is ready. All 16 signatures are checked
//   in parallel by a row of 15 byte cells that shift the file history.
// The verdict is registered and appears in the cycle after the closing word is taken.
// Scanning stops at the first zero byte or once scan_byte_limit bytes were
//   examined; later bytes of that file are ignored.
// Stall: the result register frees in the cycle the sink takes it, so item
//   stays ready while a verdict waits only if result.ready is high; with
//   result stalled and full, item.ready drops.
// Reset (arst_n low): history, mask, count and stop flag clear, the limit
//   returns to 1048576, no result is pending.
module signature_byte_stream_matcher_core (
	input  logic      clk,
	input  logic      arst_n,
	sbm_in_if.sink    item,
	sbm_out_if.source result,
	sbm_cfg_if.sink   cfg
);
	import sbm_pkg::*;

	limit_t    limit_q;
	limit_t    cnt_q;
	sig_mask_t seen_q;
	logic      stop_q;

	logic      free;
	logic      accept;
	logic      live;
	logic      examine;
	logic      halt;
	logic      close;
	sig_mask_t sig_hit;
	sig_mask_t seen_nxt;
	result_t   res_d;

	byte_t     chain [SIG_MAX+1];
	sig_mask_t col   [SIG_MAX];

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (cfg.valid) begin
			limit_q <= cfg.scan_byte_limit;
		end
	end

	// Handshake and per-byte decisions
	assign item.ready = free;
	assign accept     = item.valid && free;
	assign live       = item.byte_present && !stop_q && (cnt_q < limit_q);
	assign examine    = accept && live && (item.data_byte != 8'h00);
	assign halt       = accept && live && (item.data_byte == 8'h00);
	assign close      = accept && item.end_of_file;

	// Cell row: cell i sees the byte i positions back (cell 0: the new byte)
	assign chain[0] = item.data_byte;

	for (genvar i = 0; i < SIG_MAX; i++) begin : g_cell
		sbm_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.pos     (POS_W'(i)),
			.shift   (examine),
			.clear   (close),
			.byte_in (chain[i]),
			.byte_q  (chain[i+1]),
			.col_hit (col[i])
		);
	end

	always_comb begin
		sig_hit = '1;
		for (int i = 0; i < SIG_MAX; i++) begin
			sig_hit = sig_hit & col[i];
		end
	end

	assign seen_nxt = seen_q | (examine ? sig_hit : '0);

	// Per-file state; cleared when the closing word is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			seen_q <= '0;
			stop_q <= 1'b0;
		end else if (close) begin
			cnt_q  <= '0;
			seen_q <= '0;
			stop_q <= 1'b0;
		end else begin
			seen_q <= seen_nxt;
			if (examine) cnt_q <= cnt_q + LIMIT_W'(1);
			if (halt) stop_q <= 1'b1;
		end
	end

	assign res_d.verdict         = |seen_nxt;
	assign res_d.first_signature = first_set(seen_nxt);
	assign res_d.found_mask      = seen_nxt;

	sbm_out_stage u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (close),
		.res_in (res_d),
		.free   (free),
		.result (result)
	);

	// The last cell's stored byte is beyond the longest signature.
	logic unused_tail;
	assign unused_tail = ^chain[SIG_MAX];
endmodule

// File: rtl/core/sbm_checker.sv
// Port-level checker for the matcher core, bound to the top level.
module sbm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        item_valid,
	input logic        item_ready,
	input logic        item_eof,
	input logic        res_valid,
	input logic        res_ready,
	input logic        verdict,
	input logic [3:0]  first_signature,
	input logic [15:0] found_mask
);
	import sbm_pkg::*;

	// A stalled verdict holds its word.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(found_mask) &&
			$stable(first_signature) && $stable(verdict))
		else $error("result word changed while stalled");

	// Closing word gives a verdict in the next cycle.
	a_eof_result: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_eof |=> res_valid)
		else $error("no verdict after end of file");

	a_verdict_mask: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (verdict == (found_mask != 16'h0000)))
		else $error("verdict disagrees with mask");

	a_clean_index: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !verdict |-> first_signature == 4'h0)
		else $error("clean verdict with nonzero index");

	a_first_low: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && verdict |-> found_mask[first_signature] &&
			((found_mask & ((16'h0001 << first_signature) - 16'h0001)) == 16'h0000))
		else $error("first signature is not the lowest found");
endmodule

bind signature_byte_stream_matcher_core sbm_checker u_sbm_checker (
	.clk             (clk),
	.arst_n          (arst_n),
	.item_valid      (item.valid),
	.item_ready      (item.ready),
	.item_eof        (item.end_of_file),
	.res_valid       (result.valid),
	.res_ready       (result.ready),
	.verdict         (result.verdict),
	.first_signature (result.first_signature),
	.found_mask      (result.found_mask)
);
